[rtl/frame_difference_probability_defines.svh]
// assertion macros for the frame difference probability block
// expects clk and rst_n in the scope where a macro is used
`ifndef FRAME_DIFFERENCE_PROBABILITY_DEFINES_SVH
`define FRAME_DIFFERENCE_PROBABILITY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fdp_pkg.sv]
// shared types and constants of the frame difference probability block
// no dependencies
package fdp_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_WINDOW = 15;
    localparam int MAX_HEIGHT     = 1024;

    localparam int ROW_W      = 10;
    localparam int H_W        = 11;
    localparam int CHAN_W     = 8;
    localparam int ESUM_W     = 18;
    localparam int PROB_W     = 17;
    localparam int FW_W       = 11;
    localparam int WS_W       = 4;
    localparam int K_W        = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // quotient of the divider in q1.24, one integer bit
    localparam int Q_BITS      = 24;
    localparam int Q_W         = Q_BITS + 1;
    localparam int ROUND_SHIFT = 2 * Q_BITS - 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_K      = 3'd3;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FW_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [WS_W-1:0] RST_WINDOW_SIZE  = 4'd5;
    localparam logic [K_W-1:0]  RST_SCALE_K      = 32'd22500;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] red_a;
        logic [CHAN_W-1:0] green_a;
        logic [CHAN_W-1:0] blue_a;
        logic [CHAN_W-1:0] red_b;
        logic [CHAN_W-1:0] green_b;
        logic [CHAN_W-1:0] blue_b;
    } pix_word_t;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              last;
    } res_word_t;

    function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] x,
                                                   input logic [CHAN_W-1:0] y);
        logic [CHAN_W-1:0] d;
        d = (x > y) ? (x - y) : (y - x);
        return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
    endfunction

endpackage

[rtl/fdp_stream_if.sv]
// valid/ready stream channel carrying one word per handshake
// word type comes from fdp_pkg at the point of use
interface fdp_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/frame_difference_probability.sv]
// a word that yields no result passes the check state back to idle; one that yields a
// result, pixel or drain, passes check, the walk (a = size/2 steps), the one-read-per-cycle
// window sweep of the line memory, sum wait, divider init, the bit-serial 25-step divider,
// multiply and output, held while the output register is full. one word at a time.
// rst_n clears counters, control and configuration registers to their defaults; the line
// memory and datapath registers are not cleared; a configuration write restarts the stream.
// depends on fdp_pkg, fdp_stream_if, fdp_ram and the assertion macro header
`include "frame_difference_probability_defines.svh"

module frame_difference_probability
    import fdp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fdp_stream_if.sink            pix,
    fdp_stream_if.source          res
);

    localparam int CB       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int RB       = $clog2(MAX_WINDOW + 1);
    localparam int SZW      = $clog2(MAX_WINDOW + 1);
    localparam int AW       = RB + CB;
    localparam int DEPTH    = 1 << AW;
    localparam int XW       = (CB > ROW_W) ? CB : ROW_W;
    localparam int SPAN_MAX = (MAX_WINDOW / 2 + 1) * MAX_WIDTH;
    localparam int PW       = $clog2(SPAN_MAX + 1);
    localparam int ACC_W    = ESUM_W + $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int DEN_W    = ((ACC_W > K_W) ? ACC_W : K_W) + 1;
    localparam int REM_W    = DEN_W + 1;
    localparam int DC_W     = $clog2(Q_W);
    localparam int PROD_W   = 2 * Q_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_WALK  = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_SUMW  = 4'd4;
    localparam logic [3:0] ST_DINIT = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_MUL   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    // one step of a reflect-101 walk; dir 0 moves down, 1 moves up
    function automatic logic [XW:0] walk_step(input logic [XW-1:0] p, input logic dir,
                                             input logic [XW:0] n);
        logic [XW-1:0] np;
        logic          nd;
        np = p;
        nd = dir;
        if (n <= (XW+1)'(1))
        begin
            np = '0;
        end
        else if (!dir)
        begin
            if (p == '0)
            begin
                np = XW'(1);
                nd = 1'b1;
            end
            else
            begin
                np = p - XW'(1);
            end
        end
        else
        begin
            if ({1'b0, p} == n - (XW+1)'(1))
            begin
                np = XW'(n - (XW+1)'(2));
                nd = 1'b0;
            end
            else
            begin
                np = p + XW'(1);
            end
        end
        return {nd, np};
    endfunction

    // configuration
    logic [FW_W-1:0] frame_width_reg, frame_width_next;
    logic [FW_W-1:0] frame_height_reg, frame_height_next;
    logic [WS_W-1:0] window_size_reg, window_size_next;
    logic [K_W-1:0]  scale_k_reg, scale_k_next;

    // control
    logic [3:0]     state_reg, state_next;
    logic [CB-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [RB-1:0]  in_slot_reg, in_slot_next;
    logic [CB-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [RB-1:0]  out_slot_reg, out_slot_next;
    logic [PW-1:0]  pend_reg, pend_next;
    logic           op_reg, op_next;
    logic           last_reg, last_next;
    logic [SZW-1:0] walk_cnt_reg, walk_cnt_next;
    logic [SZW-1:0] dx_reg, dx_next;
    logic [SZW-1:0] dy_reg, dy_next;
    logic [DC_W-1:0] div_cnt_reg, div_cnt_next;
    logic           rd_v_reg, rd_v_next;
    logic           res_valid_reg, res_valid_next;

    // datapath
    logic [XW-1:0]  rp_reg, rp_next;
    logic           rdir_reg, rdir_next;
    logic [XW-1:0]  cp_reg, cp_next;
    logic           cdir_reg, cdir_next;
    logic [XW-1:0]  cs_p_reg, cs_p_next;
    logic           cs_dir_reg, cs_dir_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic             dzero_reg, dzero_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    res_word_t         res_data_reg, res_data_next;

    // effective configuration
    logic [WW-1:0]  w_eff;
    logic [H_W-1:0] h_eff;
    logic [SZW-1:0] size_eff;
    logic [SZW-1:0] a_eff;
    logic [31:0]    span;
    logic [31:0]    need;
    logic [31:0]    m_row;
    logic           emit;
    logic [XW:0]    n_row;
    logic [XW:0]    n_col;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = H_W'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = H_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;

        if (window_size_reg == '0)
            size_eff = SZW'(1);
        else if (32'(window_size_reg) > MAX_WINDOW)
            size_eff = SZW'(MAX_WINDOW);
        else
            size_eff = SZW'(window_size_reg);
    end

    assign a_eff = size_eff >> 1;
    assign span  = (32'(a_eff) + 32'd1) * 32'(w_eff);
    assign n_row = (XW+1)'(h_eff);
    assign n_col = (XW+1)'(w_eff);

    always_comb
    begin
        m_row = 32'(out_row_reg) + 32'(a_eff);
        if (m_row > 32'(h_eff) - 32'd1)
            m_row = 32'(h_eff) - 32'd1;
    end

    assign need = (m_row - 32'(out_row_reg) + 32'd1) * 32'(w_eff) - 32'(out_col_reg);
    assign emit = (32'(pend_reg) >= need) &&
                  ((32'(pend_reg) > span - 32'd1) || (op_reg == OP_DRAIN));

    // line memory
    logic              pix_fire;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ESUM_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [ESUM_W-1:0] mem_rdata;
    logic [RB-1:0]     rd_slot;

    assign pix.ready = (state_reg == ST_IDLE);
    assign pix_fire  = pix.valid && pix.ready;
    assign mem_we    = pix_fire && (pix.data.op == OP_PIXEL);
    assign mem_waddr = {in_slot_reg, in_col_reg};
    assign mem_wdata = ESUM_W'(sq_diff(pix.data.red_a, pix.data.red_b))
                     + ESUM_W'(sq_diff(pix.data.green_a, pix.data.green_b))
                     + ESUM_W'(sq_diff(pix.data.blue_a, pix.data.blue_b));
    assign rd_slot   = out_slot_reg + rp_reg[RB-1:0] - out_row_reg[RB-1:0];
    assign mem_raddr = {rd_slot, cp_reg[CB-1:0]};

    fdp_ram #(
        .WIDTH (ESUM_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic [XW:0]       rstep;
    logic [XW:0]       cstep;
    logic [REM_W-1:0]  rem_sub;
    logic              q_bit;
    logic [PROD_W:0]   rounded;

    assign rstep   = walk_step(rp_reg, rdir_reg, n_row);
    assign cstep   = walk_step(cp_reg, cdir_reg, n_col);
    assign q_bit   = (rem_reg >= REM_W'(den_reg));
    assign rem_sub = q_bit ? (rem_reg - REM_W'(den_reg)) : rem_reg;
    assign rounded = (PROD_W+1)'(prod_reg) + ((PROD_W+1)'(1) << (ROUND_SHIFT - 1));

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        window_size_next  = window_size_reg;
        scale_k_next      = scale_k_reg;
        state_next        = state_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        in_slot_next      = in_slot_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        out_slot_next     = out_slot_reg;
        pend_next         = pend_reg;
        op_next           = op_reg;
        last_next         = last_reg;
        walk_cnt_next     = walk_cnt_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        div_cnt_next      = div_cnt_reg;
        rd_v_next         = (state_reg == ST_SUM);
        res_valid_next    = res_valid_reg && !res.ready;
        rp_next           = rp_reg;
        rdir_next         = rdir_reg;
        cp_next           = cp_reg;
        cdir_next         = cdir_reg;
        cs_p_next         = cs_p_reg;
        cs_dir_next       = cs_dir_reg;
        acc_next          = rd_v_reg ? (acc_reg + ACC_W'(mem_rdata)) : acc_reg;
        den_next          = den_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        dzero_next        = dzero_reg;
        prod_next         = prod_reg;
        res_data_next     = res_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pix_fire)
                begin
                    op_next    = pix.data.op;
                    state_next = ST_CHECK;
                    if (pix.data.op == OP_PIXEL)
                    begin
                        pend_next = pend_reg + PW'(1);
                        if (32'(in_col_reg) + 32'd1 >= 32'(w_eff))
                        begin
                            in_col_next  = '0;
                            in_slot_next = in_slot_reg + RB'(1);
                            if (32'(in_row_reg) + 32'd1 >= 32'(h_eff))
                                in_row_next = '0;
                            else
                                in_row_next = in_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + CB'(1);
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                last_next     = (32'(out_row_reg) == 32'(h_eff) - 32'd1) &&
                                (32'(out_col_reg) == 32'(w_eff) - 32'd1);
                rp_next       = XW'(out_row_reg);
                cp_next       = XW'(out_col_reg);
                cs_p_next     = XW'(out_col_reg);
                acc_next      = '0;
                walk_cnt_next = '0;
                dx_next       = '0;
                dy_next       = '0;
                // without a walk the forward direction is up
                rdir_next     = (a_eff == '0);
                cdir_next     = (a_eff == '0);
                cs_dir_next   = 1'b1;
                if (!emit)
                    state_next = ST_IDLE;
                else if (a_eff == '0)
                    state_next = ST_SUM;
                else
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                rp_next       = rstep[XW-1:0];
                rdir_next     = rstep[XW];
                cp_next       = cstep[XW-1:0];
                cdir_next     = cstep[XW];
                walk_cnt_next = walk_cnt_reg + SZW'(1);
                if (walk_cnt_reg == a_eff - SZW'(1))
                begin
                    // turn around to sweep the window forward
                    rdir_next   = !rstep[XW];
                    cdir_next   = !cstep[XW];
                    cs_p_next   = cstep[XW-1:0];
                    cs_dir_next = !cstep[XW];
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (dx_reg == size_eff - SZW'(1))
                begin
                    dx_next   = '0;
                    cp_next   = cs_p_reg;
                    cdir_next = cs_dir_reg;
                    rp_next   = rstep[XW-1:0];
                    rdir_next = rstep[XW];
                    if (dy_reg == size_eff - SZW'(1))
                        state_next = ST_SUMW;
                    else
                        dy_next = dy_reg + SZW'(1);
                end
                else
                begin
                    dx_next   = dx_reg + SZW'(1);
                    cp_next   = cstep[XW-1:0];
                    cdir_next = cstep[XW];
                end
            end
            ST_SUMW:
            begin
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                den_next     = DEN_W'(scale_k_reg) + DEN_W'(acc_reg);
                dzero_next   = (scale_k_reg == '0) && (acc_reg == '0);
                rem_next     = REM_W'(scale_k_reg);
                quo_next     = '0;
                div_cnt_next = DC_W'(Q_W - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next     = {quo_reg[Q_W-2:0], q_bit};
                rem_next     = rem_sub << 1;
                div_cnt_next = div_cnt_reg - DC_W'(1);
                if (div_cnt_reg == '0)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(quo_reg) * PROD_W'(quo_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next     = 1'b1;
                    res_data_next.last = last_reg;
                    if (dzero_reg)
                        res_data_next.prob = PROB_W'(1) << 16;
                    else
                        res_data_next.prob = rounded[ROUND_SHIFT +: PROB_W];
                    pend_next = pend_reg - PW'(1);
                    if (32'(out_col_reg) + 32'd1 >= 32'(w_eff))
                    begin
                        out_col_next  = '0;
                        out_slot_next = out_slot_reg + RB'(1);
                        if (32'(out_row_reg) + 32'd1 >= 32'(h_eff))
                            out_row_next = '0;
                        else
                            out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + CB'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write restarts the stream
        if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
                       cfg_index == REG_WINDOW_SIZE || cfg_index == REG_SCALE_K))
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data[FW_W-1:0];
                REG_WINDOW_SIZE:  window_size_next  = cfg_data[WS_W-1:0];
                REG_SCALE_K:      scale_k_next      = cfg_data[K_W-1:0];
                default:          scale_k_next      = scale_k_reg;
            endcase
            in_col_next    = '0;
            in_row_next    = '0;
            in_slot_next   = '0;
            out_col_next   = '0;
            out_row_next   = '0;
            out_slot_next  = '0;
            pend_next      = '0;
            state_next     = ST_IDLE;
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            window_size_reg  <= RST_WINDOW_SIZE;
            scale_k_reg      <= RST_SCALE_K;
            state_reg        <= ST_IDLE;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            in_slot_reg      <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_slot_reg     <= '0;
            pend_reg         <= '0;
            op_reg           <= OP_PIXEL;
            last_reg         <= 1'b0;
            walk_cnt_reg     <= '0;
            dx_reg           <= '0;
            dy_reg           <= '0;
            div_cnt_reg      <= '0;
            rd_v_reg         <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            window_size_reg  <= window_size_next;
            scale_k_reg      <= scale_k_next;
            state_reg        <= state_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            in_slot_reg      <= in_slot_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            out_slot_reg     <= out_slot_next;
            pend_reg         <= pend_next;
            op_reg           <= op_next;
            last_reg         <= last_next;
            walk_cnt_reg     <= walk_cnt_next;
            dx_reg           <= dx_next;
            dy_reg           <= dy_next;
            div_cnt_reg      <= div_cnt_next;
            rd_v_reg         <= rd_v_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg       <= rp_next;
        rdir_reg     <= rdir_next;
        cp_reg       <= cp_next;
        cdir_reg     <= cdir_next;
        cs_p_reg     <= cs_p_next;
        cs_dir_reg   <= cs_dir_next;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dzero_reg    <= dzero_next;
        prod_reg     <= prod_next;
        res_data_reg <= res_data_next;
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // pending count never outgrows the window span
    `FDP_ASSERT_NOW(a_pend_bound, 1'b1, 32'(pend_reg) <= span, "pending count beyond span")
    // quotient is at most one in q1.24 unless the denominator is zero
    `FDP_ASSERT_NOW(a_quo_range, state_reg == ST_MUL && !dzero_reg,
        quo_reg <= (Q_W'(1) << Q_BITS), "divider quotient out of range")
    // a new result word only comes from the output state
    `FDP_ASSERT_NEXT(a_res_source, !res_valid_reg && state_reg != ST_OUT, !res_valid_reg,
        "result word without computation")

endmodule

[rtl/fdp_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
module fdp_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sim/tb_frame_difference_probability.sv]
// testbench for frame_difference_probability: random pixel streams over small frames,
// checked word by word against an in-bench predictor of the box-filtered probability
// depends on fdp_pkg, fdp_stream_if and the block itself
module tb_frame_difference_probability;
    import fdp_pkg::*;

    localparam int RING_ROWS   = DEF_MAX_WINDOW + 1;
    localparam int DRAIN_WAIT  = 320;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_WORDS = 1800;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fdp_stream_if #(.word_t(pix_word_t)) pix_ch ();
    fdp_stream_if #(.word_t(res_word_t)) res_ch ();

    frame_difference_probability dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_ch),
        .res       (res_ch)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [FW_W-1:0] cur_width, cur_height;
    logic [WS_W-1:0] cur_size;
    logic [K_W-1:0] cur_k;
    logic [ESUM_W-1:0] energy_ring [RING_ROWS*DEF_MAX_WIDTH];
    int unsigned wr_col, wr_row, rd_col, rd_row, wr_slot, rd_slot, unanswered;

    pix_word_t pixel_q [$];
    res_word_t prob_expect_q [$];
    int unsigned words_queued, words_in, results_seen, last_seen, errors, cycles;
    int unsigned send_idle, recv_idle;

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // reflect-101 border index
    function automatic int unsigned mirror101(int i, int unsigned n);
        int m;
        m = n;
        if (n <= 1) return 0;
        while (i < 0 || i >= m)
        begin
            if (i < 0) i = -i;
            if (i >= m) i = 2 * m - 2 - i;
        end
        return i;
    endfunction

    function automatic int unsigned chan_energy(logic [7:0] x, logic [7:0] y);
        int unsigned d;
        d = (x > y) ? x - y : y - x;
        return d * d;
    endfunction

    function void restart_stream();
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
        wr_slot = 0; rd_slot = 0; unanswered = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:  cur_width = val[FW_W-1:0];
            REG_FRAME_HEIGHT: cur_height = val[FW_W-1:0];
            REG_WINDOW_SIZE:  cur_size = val[WS_W-1:0];
            REG_SCALE_K:      cur_k = val;
            default: return;
        endcase
        restart_stream();
    endfunction

    // returns 1 when the word yields a probability
    function bit predict_probability(input pix_word_t wd, output res_word_t r);
        int unsigned w, h, sz, a, lat, m, need, q, slot, col;
        longint unsigned s, k, d, t, p;
        w = clamp_range(32'(cur_width), 1, DEF_MAX_WIDTH);
        h = clamp_range(32'(cur_height), 1, MAX_HEIGHT);
        sz = clamp_range(32'(cur_size), 1, DEF_MAX_WINDOW);
        a = sz / 2;
        lat = (a + 1) * w - 1;
        r = '0;
        if (wd.op == OP_PIXEL)
        begin
            energy_ring[wr_slot*DEF_MAX_WIDTH + wr_col] = ESUM_W'(
                chan_energy(wd.red_a, wd.red_b) + chan_energy(wd.green_a, wd.green_b)
                + chan_energy(wd.blue_a, wd.blue_b));
            wr_col++;
            if (wr_col >= w)
            begin
                wr_col = 0;
                wr_slot = (wr_slot + 1) % RING_ROWS;
                wr_row++;
                if (wr_row >= h) wr_row = 0;
            end
            unanswered++;
        end
        m = rd_row + a;
        if (m > h - 1) m = h - 1;
        need = (m - rd_row + 1) * w - rd_col;
        if (unanswered < need) return 0;
        if (!(unanswered > lat || wd.op == OP_DRAIN)) return 0;
        s = 0;
        for (int dy = 0; dy < sz; dy++)
        begin
            q = mirror101(int'(rd_row) - int'(a) + dy, h);
            slot = (rd_slot + RING_ROWS + q - rd_row) % RING_ROWS;
            for (int dx = 0; dx < sz; dx++)
            begin
                col = mirror101(int'(rd_col) - int'(a) + dx, w);
                s += energy_ring[slot*DEF_MAX_WIDTH + col];
            end
        end
        k = cur_k;
        d = k + s;
        if (d == 0)
            p = 65536;
        else
        begin
            t = (k << 24) / d;
            p = (t * t + (64'd1 << 31)) >> 32;
        end
        r.prob = p[PROB_W-1:0];
        r.last = (rd_row == h - 1 && rd_col == w - 1);
        unanswered--;
        rd_col++;
        if (rd_col >= w)
        begin
            rd_col = 0;
            rd_slot = (rd_slot + 1) % RING_ROWS;
            rd_row++;
            if (rd_row >= h) rd_row = 0;
        end
        return 1;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ch.valid <= 1'b0;
            pix_ch.data <= '0;
        end
        else if (!pix_ch.valid || pix_ch.ready)
        begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                pix_ch.valid <= 1'b1;
                pix_ch.data <= pixel_q.pop_front();
            end
            else
                pix_ch.valid <= 1'b0;
        end
    end

    // receiver stalls and monitor
    always @(posedge clk or negedge rst_n)
    begin
        res_word_t r;
        res_word_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle);
            if (pix_ch.valid && pix_ch.ready)
            begin
                words_in++;
                if (predict_probability(pix_ch.data, r))
                    prob_expect_q.push_back(r);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (res_ch.data.last) last_seen++;
                if (prob_expect_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word prob %0d last %0d", $time,
                             res_ch.data.prob, res_ch.data.last);
                end
                else
                begin
                    want = prob_expect_q.pop_front();
                    if (want.prob !== res_ch.data.prob)
                    begin
                        errors++;
                        $display("%0t prob expected %0d actual %0d", $time, want.prob,
                                 res_ch.data.prob);
                    end
                    if (want.last !== res_ch.data.last)
                    begin
                        errors++;
                        $display("%0t last expected %0d actual %0d", $time, want.last,
                                 res_ch.data.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        // idling pattern follows progress through the stream
        if (words_in < RANDOM_WORDS / 3)
        begin
            send_idle = 38; recv_idle = 48;
        end
        else if (words_in < 2 * RANDOM_WORDS / 3)
        begin
            send_idle = 48; recv_idle = 38;
        end
        else
        begin
            send_idle = 0; recv_idle = 0;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL frame_difference_probability");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pixel_q.size() != 0 || pix_ch.valid || prob_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        apply_register(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(int unsigned w, int unsigned h, int unsigned sz, logic [31:0] k);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_WINDOW_SIZE, sz);
        write_reg(REG_SCALE_K, k);
    endtask

    task automatic push_word(pix_word_t wd);
        pixel_q.push_back(wd);
        words_queued++;
    endtask

    task automatic push_pixel(int same_pct);
        pix_word_t wd;
        wd.op = OP_PIXEL;
        wd.red_a = 8'($urandom); wd.green_a = 8'($urandom); wd.blue_a = 8'($urandom);
        if ($urandom_range(99) < same_pct)
        begin
            wd.red_b = wd.red_a; wd.green_b = wd.green_a; wd.blue_b = wd.blue_a;
        end
        else if ($urandom_range(1))
        begin
            wd.red_b = 8'(wd.red_a + $urandom_range(3));
            wd.green_b = 8'(wd.green_a - $urandom_range(3));
            wd.blue_b = 8'(wd.blue_a ^ $urandom_range(7));
        end
        else
        begin
            wd.red_b = 8'($urandom); wd.green_b = 8'($urandom); wd.blue_b = 8'($urandom);
        end
        push_word(wd);
    endtask

    task automatic push_drains(int n);
        pix_word_t wd;
        wd = '0;
        wd.op = OP_DRAIN;
        repeat (n)
        begin
            wd.red_a = 8'($urandom); wd.blue_b = 8'($urandom);
            push_word(wd);
        end
    endtask

    initial
    begin
        pix_word_t wd;
        int unsigned w, h, sz, nframes, npix;
        logic [31:0] k;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        pix_ch.valid = 1'b0; pix_ch.data = '0; res_ch.ready = 1'b0;
        send_idle = 38; recv_idle = 48;
        cur_width = RST_FRAME_WIDTH; cur_height = RST_FRAME_HEIGHT;
        cur_size = RST_WINDOW_SIZE; cur_k = RST_SCALE_K;
        restart_stream();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // zero scale, one pixel all-zero against all-ones: windows that hold it see a change
        setup(3, 2, 3, 0);
        wd = '0;
        wd.red_b = 8'hFF; wd.green_b = 8'hFF; wd.blue_b = 8'hFF;
        push_word(wd);
        repeat (5) push_pixel(100);
        push_drains(4);
        wait_idle();
        // zero scale, no change: zero denominator
        write_reg(REG_SCALE_K, 0);
        repeat (6) push_pixel(100);
        push_drains(3);
        wait_idle();
        // single row and column after clamping, drain with nothing pending
        setup(0, 0, 0, 1);
        push_pixel(0);
        push_drains(2);
        wait_idle();
        // upper clamps, largest scale; unknown index leaves the stream running
        setup(2047, 2047, 15, 32'hFFFF_FFFF);
        push_pixel(0);
        push_pixel(50);
        wait_idle();
        write_reg(REG_UNUSED, 32'h5A5A_5A5A);
        push_pixel(0);
        wait_idle();
        setup(1, 2047, 15, 32'hFFFF_FFFF);
        repeat (12) push_pixel(30);
        wait_idle();

        while (words_queued < RANDOM_WORDS)
        begin
            w = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            sz = $urandom_range(0, 15);
            case ($urandom_range(3))
                0: k = ($urandom_range(1)) ? 0 : 32'hFFFF_FFFF;
                1: k = $urandom_range(1, 2000);
                2: k = $urandom_range(2000, 200000);
                default: k = $urandom;
            endcase
            setup(w, h, sz, k);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++)
            begin
                npix = w * h;
                if ($urandom_range(19) == 0) npix = $urandom_range(1, npix);
                for (int i = 0; i < npix; i++)
                begin
                    push_pixel($urandom_range(1) ? 20 : 80);
                    if ($urandom_range(9) == 0) push_drains(1);
                end
                if (f == nframes - 1 || $urandom_range(4) != 0)
                    push_drains((sz / 2 + 1) * w + 2);
            end
            wait_idle();
        end

        wait_idle();
        $display("covered %0d words in, %0d probabilities checked, %0d frame ends",
                 words_in, results_seen, last_seen);
        if (errors == 0)
            $display("PASS frame_difference_probability");
        else
            $display("FAIL frame_difference_probability");
        $finish;
    end

endmodule
